### hdl/dhce_pkg.sv
package dhce_pkg;

  // Default width of record positions and file sizes.
  localparam int POS_WIDTH_DEF = 32;

  // Width of the lead and trail context registers.
  localparam int CTX_WIDTH = 16;

  // Configuration port geometry.
  localparam int CFG_DATA_WIDTH = 32;
  localparam int CFG_ADDR_WIDTH = 2;

  // Depth of the result queue behind the compare stage.
  localparam int OUT_FIFO_DEPTH = 4;

  // Reset value of both context registers.
  localparam logic [CTX_WIDTH-1:0] CTX_RESET = CTX_WIDTH'(3);

  // Configuration register indexes.
  typedef enum logic [CFG_ADDR_WIDTH-1:0] {
    REG_FILE_SIZE_A  = 2'd0,
    REG_FILE_SIZE_B  = 2'd1,
    REG_LEAD_CONTEXT = 2'd2,
    REG_TRAIL_CONTEXT = 2'd3
  } cfg_reg_t;

endpackage

### hdl/diff_hunk_context_expander.sv
// Widens a stream of diff deltas into hunks with lead and trail context. A delta
// request is taken on every cycle in steady flow: the context sums are formed as the
// request is registered, and past the compare stage the finished hunks enter a
// four-entry result queue. Each delta is held until its successor arrives, so a
// non-final delta yields no hunk yet, the next one yields the held hunk, and a final
// delta yields the held hunk (if any) and then its own hunk, marked by out_tlast,
// after which a new stream begins. Every delta yields one hunk in all, so the result
// port, which moves one hunk per cycle while out_tready is high, keeps up with one
// delta per cycle; when a final delta follows a held one, both hunks enter the queue
// at once and the queue absorbs the second. The input stalls whenever a delta is
// registered and the queue cannot take two more hunks. Configuration registers
// must be written only while no delta is in flight; the block does not enforce it.
module diff_hunk_context_expander #(
  parameter int POS_WIDTH = dhce_pkg::POS_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,

  // Configuration write port.
  input  logic                                 cfg_we,
  input  logic [dhce_pkg::CFG_ADDR_WIDTH-1:0]  cfg_addr,
  input  logic [dhce_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata,

  // Delta input. tdata, lowest bit up: delta_start_a, delta_start_b,
  // delta_stop_a, delta_stop_b, zero fill. tlast: final_delta.
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [((4*POS_WIDTH+7)/8)*8-1:0]     in_tdata,
  input  logic                                 in_tlast,

  // Hunk output. tdata, lowest bit up: hunk_start_a, hunk_start_b,
  // hunk_stop_a, hunk_stop_b, zero fill. tlast: final_hunk.
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [((4*POS_WIDTH+7)/8)*8-1:0]     out_tdata,
  output logic                                 out_tlast
);

  localparam int P      = POS_WIDTH;
  localparam int CW     = dhce_pkg::CTX_WIDTH;
  localparam int SW     = ((P > CW) ? P : CW) + 1;
  localparam int TW     = ((4 * P + 7) / 8) * 8;
  localparam int DEPTH  = dhce_pkg::OUT_FIFO_DEPTH;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef struct packed {
    logic [P-1:0] start_a;
    logic [P-1:0] start_b;
    logic [P-1:0] stop_a;
    logic [P-1:0] stop_b;
    logic         last;
  } hunk_t;

  // Configuration registers.
  logic [P-1:0]  file_size_a_r;
  logic [P-1:0]  file_size_b_r;
  logic [CW-1:0] lead_ctx_r;
  logic [CW-1:0] trail_ctx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_size_a_r <= '0;
      file_size_b_r <= '0;
      lead_ctx_r    <= dhce_pkg::CTX_RESET;
      trail_ctx_r   <= dhce_pkg::CTX_RESET;
    end else if (cfg_we) begin
      case (dhce_pkg::cfg_reg_t'(cfg_addr))
        dhce_pkg::REG_FILE_SIZE_A:   file_size_a_r <= cfg_wdata[P-1:0];
        dhce_pkg::REG_FILE_SIZE_B:   file_size_b_r <= cfg_wdata[P-1:0];
        dhce_pkg::REG_LEAD_CONTEXT:  lead_ctx_r    <= cfg_wdata[CW-1:0];
        dhce_pkg::REG_TRAIL_CONTEXT: trail_ctx_r   <= cfg_wdata[CW-1:0];
        default: ;
      endcase
    end
  end

  // Unpack the incoming request and form the context sums.
  logic [P-1:0]  in_sa, in_sb, in_ea, in_eb;
  logic [SW-1:0] in_sa_x, in_sb_x, lead_x, trail_x;

  assign in_sa   = in_tdata[P-1:0];
  assign in_sb   = in_tdata[2*P-1:P];
  assign in_ea   = in_tdata[3*P-1:2*P];
  assign in_eb   = in_tdata[4*P-1:3*P];
  assign in_sa_x = SW'(in_sa);
  assign in_sb_x = SW'(in_sb);
  assign lead_x  = SW'(lead_ctx_r);
  assign trail_x = SW'(trail_ctx_r);

  // Registered delta with precomputed sums.
  logic          v1_r;
  logic          last1_r;
  logic [P-1:0]  sa1_r, sb1_r;
  logic [P-1:0]  sa_d1_r, sb_d1_r;
  logic          sa_gt1_r, sb_gt1_r;
  logic [SW-1:0] ea_g1_r, eb_g1_r;
  logic          s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (in_tready) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      last1_r  <= in_tlast;
      sa1_r    <= in_sa;
      sb1_r    <= in_sb;
      sa_d1_r  <= P'(in_sa_x - lead_x);
      sb_d1_r  <= P'(in_sb_x - lead_x);
      sa_gt1_r <= in_sa_x > lead_x;
      sb_gt1_r <= in_sb_x > lead_x;
      ea_g1_r  <= SW'(in_ea) + trail_x;
      eb_g1_r  <= SW'(in_eb) + trail_x;
    end
  end

  // Held delta: widened start and its trail-extended stop.
  logic          held_valid_r;
  logic [P-1:0]  held_start_a_r, held_start_b_r;
  logic [SW-1:0] prior_grown_a_r, prior_grown_b_r;

  // Clamp the held end to this start; the start then sits at or above that end.
  logic         hold_lt_a, hold_lt_b;
  logic [P-1:0] lo_a, lo_b;
  logic         wid_a, wid_b;
  logic [P-1:0] na, nb;

  always_comb begin
    hold_lt_a = prior_grown_a_r < SW'(sa1_r);
    hold_lt_b = prior_grown_b_r < SW'(sb1_r);
    lo_a = '0;
    lo_b = '0;
    if (held_valid_r) begin
      lo_a = hold_lt_a ? prior_grown_a_r[P-1:0] : sa1_r;
      lo_b = hold_lt_b ? prior_grown_b_r[P-1:0] : sb1_r;
      wid_a = hold_lt_a && sa_gt1_r && (prior_grown_a_r < SW'(sa_d1_r));
      wid_b = hold_lt_b && sb_gt1_r && (prior_grown_b_r < SW'(sb_d1_r));
    end else begin
      wid_a = sa_gt1_r;
      wid_b = sb_gt1_r;
    end
    na = wid_a ? sa_d1_r : lo_a;
    nb = wid_b ? sb_d1_r : lo_b;
  end

  // Hunks produced by the registered delta.
  hunk_t held_hunk, final_hunk;

  always_comb begin
    held_hunk.start_a  = held_start_a_r;
    held_hunk.start_b  = held_start_b_r;
    held_hunk.stop_a   = lo_a;
    held_hunk.stop_b   = lo_b;
    held_hunk.last     = 1'b0;
    final_hunk.start_a = na;
    final_hunk.start_b = nb;
    final_hunk.stop_a  = (ea_g1_r < SW'(file_size_a_r)) ? ea_g1_r[P-1:0] : file_size_a_r;
    final_hunk.stop_b  = (eb_g1_r < SW'(file_size_b_r)) ? eb_g1_r[P-1:0] : file_size_b_r;
    final_hunk.last    = 1'b1;
  end

  // Held state update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
    end else if (s1_go) begin
      held_valid_r <= !last1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      held_start_a_r  <= na;
      held_start_b_r  <= nb;
      prior_grown_a_r <= ea_g1_r;
      prior_grown_b_r <= eb_g1_r;
    end
  end

  // Result queue; the compare stage moves only when two entries are free.
  hunk_t              fifo_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [1:0]         push_n;
  logic               pop;

  assign s1_go     = v1_r && (cnt_r <= CNT_W'(DEPTH - 2));
  assign in_tready = !v1_r || s1_go;
  assign push_n    = s1_go ? (2'(held_valid_r) + 2'(last1_r)) : 2'd0;
  assign pop       = out_tvalid && out_tready;
  assign cnt_nxt   = cnt_r + CNT_W'(push_n) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PTR_W'(push_n);
      rd_ptr_r <= rd_ptr_r + PTR_W'(pop);
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && (held_valid_r || last1_r)) begin
      fifo_r[wr_ptr_r] <= held_valid_r ? held_hunk : final_hunk;
    end
    if (s1_go && held_valid_r && last1_r) begin
      fifo_r[wr_ptr_r + PTR_W'(1)] <= final_hunk;
    end
  end

  // Output port.
  hunk_t out_hunk;

  assign out_hunk   = fifo_r[rd_ptr_r];
  assign out_tvalid = cnt_r != '0;
  assign out_tlast  = out_hunk.last;
  assign out_tdata  = TW'({out_hunk.stop_b, out_hunk.stop_a,
                           out_hunk.start_b, out_hunk.start_a});

  // Checks on the queue and the held-delta bookkeeping.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("result queue over its depth");

  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && last1_r |=> !held_valid_r)
    else $error("held delta left after a final delta");

  a_nonfinal_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && !last1_r |=> held_valid_r)
    else $error("non-final delta not held");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == '0 |-> !pop)
    else $error("hunk taken from an empty queue");

  a_two_pushes_final: assert property (@(posedge clk) disable iff (!rst_n)
    push_n == 2'd2 |-> held_valid_r && last1_r)
    else $error("two hunks pushed for a non-final delta");

endmodule

### tb/sv/diff_hunk_checker.sv
`timescale 1ns / 1ps

// Watches the configuration port and both streams of the hunk expander, keeps its
// own copy of the register and held-delta state, and compares every hunk that
// leaves the block against the oldest predicted one.
module diff_hunk_checker #(
  parameter int POS_WIDTH = dhce_pkg::POS_WIDTH_DEF,
  parameter int DATA_W    = ((4*POS_WIDTH+7)/8)*8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [dhce_pkg::CFG_ADDR_WIDTH-1:0] cfg_addr,
  input  logic [dhce_pkg::CFG_DATA_WIDTH-1:0] cfg_wdata,
  input  logic                                in_tvalid,
  input  logic                                in_tready,
  input  logic [DATA_W-1:0]                   in_tdata,
  input  logic                                in_tlast,
  input  logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic [DATA_W-1:0]                   out_tdata,
  input  logic                                out_tlast,
  input  logic                                drain_check,
  output int                                  fail_count,
  output int                                  pending
);

  // Width of a position plus a context value, carry included.
  localparam int SUM_W =
    ((POS_WIDTH > dhce_pkg::CTX_WIDTH) ? POS_WIDTH : dhce_pkg::CTX_WIDTH) + 1;

  typedef logic [POS_WIDTH-1:0] pos_t;

  typedef struct packed {
    pos_t start_a;
    pos_t start_b;
    pos_t stop_a;
    pos_t stop_b;
    logic fin;
  } hunk_t;

  // Register copies.
  pos_t                           size_a;
  pos_t                           size_b;
  logic [dhce_pkg::CTX_WIDTH-1:0] lead_ctx;
  logic [dhce_pkg::CTX_WIDTH-1:0] trail_ctx;

  // Held delta: widened start and raw stop of the delta waiting for its successor.
  pos_t keep_start_a;
  pos_t keep_start_b;
  pos_t keep_stop_a;
  pos_t keep_stop_b;
  logic keep_valid;

  hunk_t expected_hunks[$];
  int    errors = 0;
  int    hunk_count = 0;

  task automatic note_failure(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input pos_t got, input pos_t want);
    if (got !== want)
      note_failure($sformatf("hunk %0d %s: got %h, want %h", hunk_count, name, got, want));
  endtask

  // Stop plus trail context, limited by the given bound; the sum keeps its carry.
  function automatic pos_t clamp_stop(input pos_t stop, input pos_t limit);
    logic [SUM_W-1:0] grown;
    grown = SUM_W'(stop) + SUM_W'(trail_ctx);
    return (grown < SUM_W'(limit)) ? grown[POS_WIDTH-1:0] : limit;
  endfunction

  // Start minus lead context, never below the floor.
  function automatic pos_t widen_start(input pos_t start, input pos_t floor_pos);
    logic [SUM_W-1:0] reach;
    logic [SUM_W-1:0] ext;
    ext   = SUM_W'(lead_ctx);
    reach = SUM_W'(floor_pos) + ext;
    return (reach < SUM_W'(start)) ? pos_t'(SUM_W'(start) - ext) : floor_pos;
  endfunction

  // Predict the hunks caused by one accepted delta and advance the held state.
  task automatic expand_delta(input pos_t sa, input pos_t sb, input pos_t ea,
                              input pos_t eb, input logic fin);
    pos_t  floor_a;
    pos_t  floor_b;
    pos_t  ns_a;
    pos_t  ns_b;
    hunk_t h;
    floor_a = '0;
    floor_b = '0;
    if (keep_valid) begin
      floor_a = clamp_stop(keep_stop_a, sa);
      floor_b = clamp_stop(keep_stop_b, sb);
      h = '{keep_start_a, keep_start_b, floor_a, floor_b, 1'b0};
      expected_hunks.push_back(h);
    end
    ns_a = widen_start(sa, floor_a);
    ns_b = widen_start(sb, floor_b);
    if (fin) begin
      h = '{ns_a, ns_b, clamp_stop(ea, size_a), clamp_stop(eb, size_b), 1'b1};
      expected_hunks.push_back(h);
      keep_start_a = '0;
      keep_start_b = '0;
      keep_stop_a  = '0;
      keep_stop_b  = '0;
      keep_valid   = 1'b0;
    end else begin
      keep_start_a = ns_a;
      keep_start_b = ns_b;
      keep_stop_a  = ea;
      keep_stop_b  = eb;
      keep_valid   = 1'b1;
    end
  endtask

  always @(posedge clk) begin : watch
    hunk_t want;
    if (!rst_n) begin
      size_a       = '0;
      size_b       = '0;
      lead_ctx     = dhce_pkg::CTX_RESET;
      trail_ctx    = dhce_pkg::CTX_RESET;
      keep_start_a = '0;
      keep_start_b = '0;
      keep_stop_a  = '0;
      keep_stop_b  = '0;
      keep_valid   = 1'b0;
      expected_hunks.delete();
    end else begin
      // Register writes.
      if (cfg_we) begin
        case (dhce_pkg::cfg_reg_t'(cfg_addr))
          dhce_pkg::REG_FILE_SIZE_A:   size_a    = cfg_wdata[POS_WIDTH-1:0];
          dhce_pkg::REG_FILE_SIZE_B:   size_b    = cfg_wdata[POS_WIDTH-1:0];
          dhce_pkg::REG_LEAD_CONTEXT:  lead_ctx  = cfg_wdata[dhce_pkg::CTX_WIDTH-1:0];
          dhce_pkg::REG_TRAIL_CONTEXT: trail_ctx = cfg_wdata[dhce_pkg::CTX_WIDTH-1:0];
          default: ;
        endcase
      end

      // Accepted delta requests.
      if (in_tvalid && in_tready)
        expand_delta(in_tdata[0 +: POS_WIDTH], in_tdata[POS_WIDTH +: POS_WIDTH],
                     in_tdata[2*POS_WIDTH +: POS_WIDTH], in_tdata[3*POS_WIDTH +: POS_WIDTH],
                     in_tlast);

      // Accepted hunks against the oldest prediction.
      if (out_tvalid && out_tready) begin
        if (expected_hunks.size() == 0) begin
          note_failure($sformatf("hunk %0d arrived with nothing expected: %h last %b",
                                 hunk_count, out_tdata, out_tlast));
        end else begin
          want = expected_hunks.pop_front();
          check_field("start_a", out_tdata[0 +: POS_WIDTH], want.start_a);
          check_field("start_b", out_tdata[POS_WIDTH +: POS_WIDTH], want.start_b);
          check_field("stop_a", out_tdata[2*POS_WIDTH +: POS_WIDTH], want.stop_a);
          check_field("stop_b", out_tdata[3*POS_WIDTH +: POS_WIDTH], want.stop_b);
          check_field("final", pos_t'(out_tlast), pos_t'(want.fin));
        end
        hunk_count++;
      end

      // End of run: anything still waiting never came out.
      if (drain_check && expected_hunks.size() != 0) begin
        note_failure($sformatf("%0d expected hunks never arrived", expected_hunks.size()));
        expected_hunks.delete();
      end
    end
    pending    <= expected_hunks.size();
    fail_count <= errors;
  end

endmodule

### tb/sv/tb_diff_hunk_context_expander.sv
`timescale 1ns / 1ps

// Drives delta streams and register settings into the hunk expander; the checker
// beside the block does all prediction and comparison.
module tb_diff_hunk_context_expander;

  localparam int POS_W       = dhce_pkg::POS_WIDTH_DEF;
  localparam int DATA_W      = ((4*POS_W+7)/8)*8;
  localparam int SETTLE      = 16;
  localparam int HOLD_CYCLES = 120;
  localparam int IDLE_PCT    = 23;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 64;

  typedef logic [POS_W-1:0] pos_t;

  logic                                clk;
  logic                                rst_n;
  logic                                cfg_we;
  logic [dhce_pkg::CFG_ADDR_WIDTH-1:0] cfg_addr;
  logic [dhce_pkg::CFG_DATA_WIDTH-1:0] cfg_wdata;
  logic                                in_tvalid;
  logic                                in_tready;
  logic [DATA_W-1:0]                   in_tdata;   // start_a, start_b, stop_a, stop_b (low bit up)
  logic                                in_tlast;
  logic                                out_tvalid;
  logic                                out_tready;
  logic [DATA_W-1:0]                   out_tdata;  // start_a, start_b, stop_a, stop_b (low bit up)
  logic                                out_tlast;
  logic                                drain_check;
  int                                  fail_count;
  int                                  pending;

  // Pacing controls shared with the receiver process.
  logic steady;
  int   hold_requests;

  diff_hunk_context_expander #(.POS_WIDTH(POS_W)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  diff_hunk_checker #(.POS_WIDTH(POS_W)) hunk_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .drain_check (drain_check),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #500_000;
    $display("** diff_hunk_context_expander: FAILED **");
    $finish;
  end

  // Receiver: random back-pressure, a clean stretch on request, and long hold-offs.
  initial begin
    int served;
    served     = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests > served) begin
        served++;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Random gaps before a request, skipped during the clean stretch.
  task automatic pace_sender();
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Offer one delta request and hold it until the block takes it.
  task automatic send_delta(input pos_t sa, input pos_t sb, input pos_t ea,
                            input pos_t eb, input logic fin);
    pace_sender();
    in_tvalid <= 1'b1;
    in_tdata  <= {eb, ea, sb, sa};
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Stop offering, let every predicted hunk come out, then let the pipeline settle.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write all four registers on consecutive cycles.
  task automatic set_config(input logic [dhce_pkg::CFG_DATA_WIDTH-1:0] fsize_a,
                            input logic [dhce_pkg::CFG_DATA_WIDTH-1:0] fsize_b,
                            input logic [dhce_pkg::CFG_DATA_WIDTH-1:0] lead_word,
                            input logic [dhce_pkg::CFG_DATA_WIDTH-1:0] trail_word);
    cfg_we    <= 1'b1;
    cfg_addr  <= dhce_pkg::REG_FILE_SIZE_A;
    cfg_wdata <= fsize_a;
    @(posedge clk);
    cfg_addr  <= dhce_pkg::REG_FILE_SIZE_B;
    cfg_wdata <= fsize_b;
    @(posedge clk);
    cfg_addr  <= dhce_pkg::REG_LEAD_CONTEXT;
    cfg_wdata <= lead_word;
    @(posedge clk);
    cfg_addr  <= dhce_pkg::REG_TRAIL_CONTEXT;
    cfg_wdata <= trail_word;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic pos_t pick_size();
    case ($urandom_range(3))
      0, 1:    return pos_t'($urandom_range(0, 400));
      2:       return pos_t'($urandom);
      default: return '1;
    endcase
  endfunction

  // Start position of a stream: mostly near zero, sometimes just under the top.
  function automatic pos_t pick_origin();
    if ($urandom_range(9) == 0)
      return pos_t'('1) - pos_t'($urandom_range(0, 300));
    return pos_t'($urandom_range(0, 40));
  endfunction

  // One stream: mostly ordered deltas with random gaps and lengths, sometimes noise.
  // The last delta is always final so the block ends the stream with nothing held.
  task automatic send_stream(inout int sent);
    int   count;
    logic noisy;
    pos_t cur_a;
    pos_t cur_b;
    pos_t sa;
    pos_t sb;
    count = $urandom_range(1, 8);
    noisy = ($urandom_range(4) == 0);
    cur_a = pick_origin();
    cur_b = pick_origin();
    for (int i = 0; i < count; i++) begin
      if (noisy) begin
        send_delta(pos_t'($urandom), pos_t'($urandom), pos_t'($urandom), pos_t'($urandom),
                   (i == count - 1) || ($urandom_range(5) == 0));
      end else begin
        sa    = cur_a + pos_t'($urandom_range(0, 12));
        sb    = cur_b + pos_t'($urandom_range(0, 12));
        cur_a = sa + pos_t'($urandom_range(0, 6));
        cur_b = sb + pos_t'($urandom_range(0, 6));
        send_delta(sa, sb, cur_a, cur_b, i == count - 1);
      end
      sent++;
    end
  endtask

  initial begin
    int sent;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_addr      = '0;
    cfg_wdata     = '0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tlast      = 1'b0;
    drain_check   = 1'b0;
    steady        = 1'b0;
    hold_requests = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: lone final delta, overlapping context, starts near zero.
    send_delta(0, 0, 0, 0, 1'b1);
    send_delta(10, 20, 15, 22, 1'b0);
    send_delta(17, 23, 30, 40, 1'b0);
    send_delta(100, 200, 110, 210, 1'b1);
    send_delta(1, 2, 2, 3, 1'b0);
    send_delta(5, 5, 6, 6, 1'b1);
    // Top of the position range, out-of-order and inverted intervals.
    send_delta('1, '1, '1, '1, 1'b0);
    send_delta(32'hFFFF_FFFE, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'hFFFF_FFF1, 1'b1);
    send_delta(50, 60, 40, 55, 1'b1);

    // Largest contexts and file sizes; the context words carry ones above the field.
    wait_idle();
    set_config('1, '1, '1, '1);
    send_delta(32'hFFFF_FF00, 32'h8000_0000, 32'hFFFF_FFF0, 32'h8000_0010, 1'b0);
    send_delta(32'hFFFF_FFF8, 32'h8001_0000, 32'hFFFF_FFFF, 32'h8002_0000, 1'b1);
    send_delta(32'h0000_FFFF, 32'h0001_0000, 32'h0001_0000, 32'h0001_0001, 1'b1);
    send_delta(0, 0, 5, 5, 1'b0);
    send_delta(32'h0002_0000, 32'h0001_FFFE, 32'h0002_0004, 32'h0002_0000, 1'b1);

    // No context and empty files: adjacent deltas and a final end clamped to zero.
    wait_idle();
    set_config(0, 0, 0, 0);
    send_delta(5, 5, 7, 7, 1'b0);
    send_delta(7, 7, 9, 9, 1'b0);
    send_delta(9, 9, 9, 9, 1'b1);
    send_delta(3, 4, 8, 9, 1'b1);

    // Random phases, each under its own register setting.
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      case (phase)
        0: set_config(pick_size(), pick_size(), {16'($urandom), 16'h0000},
                      {16'($urandom), 16'h0000});
        1: set_config('1, '1, {16'($urandom), 16'hFFFF}, {16'($urandom), 16'hFFFF});
        2: set_config(0, 0, $urandom_range(0, 8), $urandom_range(0, 8));
        default: set_config(pick_size(), pick_size(),
                            {16'($urandom), 16'($urandom_range(0, 10))},
                            {16'($urandom), 16'($urandom_range(0, 10))});
      endcase
      steady = (phase == 4);
      if (phase == 5) hold_requests++;
      sent = 0;
      while (sent < PHASE_ITEMS) send_stream(sent);
    end
    steady = 1'b0;

    wait_idle();
    drain_check <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("** diff_hunk_context_expander: PASSED **");
    end else begin
      $display("** diff_hunk_context_expander: FAILED **");
    end
    $finish;
  end

endmodule

### diff_hunk_context_expander.f
hdl/dhce_pkg.sv
hdl/diff_hunk_context_expander.sv
tb/sv/diff_hunk_checker.sv
tb/sv/tb_diff_hunk_context_expander.sv
